>>> design/llsc_rwl_pkg.sv
// Shared types and constants for the LL/SC reader/writer lock engine.
// Holds the payload structs, code enums and stack sizing.
// Depends on nothing; every design file refers to it by scoped names.
package llsc_rwl_pkg;

  localparam int MaxHeld = 16;
  localparam int CntW    = $clog2(MaxHeld + 1);
  localparam int IdxW    = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;
  localparam int CfgIdxW = 2;

  localparam logic [63:0] ExclBit     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SharedFull  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] WordBytes   = 16'd8;

  typedef enum logic [1:0] {
    FuncAcquire = 2'd0,
    FuncLlResp  = 2'd1,
    FuncScResp  = 2'd2,
    FuncRelease = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KindLl    = 3'd0,
    KindSc    = 3'd1,
    KindRead  = 3'd2,
    KindWrite = 3'd3,
    KindNone  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StPending   = 3'd0,
    StAcquired  = 3'd1,
    StReleased  = 3'd2,
    StRestart   = 3'd3,
    StBadPhase  = 3'd4,
    StBadShared = 3'd5,
    StOverflow  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhAcqLl = 3'd1,
    PhAcqSc = 3'd2,
    PhRelLl = 3'd3,
    PhRelSc = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeId      = 2'd0,
    CfgHeaderBytes = 2'd1,
    CfgNodeBytes   = 2'd2,
    CfgRestartAddr = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] lock_address;
    logic        want_exclusive;
    logic [63:0] response_data;
    logic        store_failed;
    logic        restart_after;
  } in_t;

  typedef struct packed {
    logic [2:0]  req_kind;
    logic [63:0] req_address;
    logic [15:0] req_bytes;
    logic [63:0] req_data;
    logic [2:0]  status;
    logic        mismatch_warning;
    logic [31:0] attempts;
  } out_t;

endpackage

>>> design/ll_sc_reader_writer_lock_engine.sv
// Top level of the LL/SC reader/writer lock engine: input register, step logic,
// lock stack and configuration registers. Uses llsc_rwl_pkg and llsc_rwl_fifo.
//
// Every transfer on the input channel produces exactly one result transfer. An item is
// taken into an input register, evaluated against the engine state and written into a
// two-entry result buffer, so the engine accepts one item per cycle while that buffer has
// room; a result is offered once it has passed the input register and been written into
// the result buffer. The cost of one item is set by a single pass through the step logic
// and one read of the 16-entry lock stack. While the output is stalled the engine still
// takes up to three more items before it deasserts ready. Configuration writes are
// always ready and should be issued only while no operation is in flight.
module ll_sc_reader_writer_lock_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  llsc_rwl_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output llsc_rwl_pkg::out_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [llsc_rwl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                          cfg_data_i
);

  typedef logic [llsc_rwl_pkg::CntW-1:0] cnt_t;
  typedef logic [llsc_rwl_pkg::IdxW-1:0] idx_t;

  // Configuration.
  logic [31:0] node_id_q;
  logic [6:0]  header_bytes_q;
  logic [15:0] node_bytes_q;
  logic [63:0] restart_addr_q;

  // Input register.
  logic              s1_valid_q, s1_valid_d;
  llsc_rwl_pkg::in_t s1_data_q;
  logic              s1_go;
  logic              fifo_room;

  // Engine state.
  llsc_rwl_pkg::phase_e phase_q, phase_d;
  cnt_t        held_cnt_q, held_cnt_d;
  cnt_t        rel_pos_q, rel_pos_d;
  logic [63:0] tgt_addr_q, tgt_addr_d;
  logic        tgt_excl_q, tgt_excl_d;
  logic [31:0] attempt_q, attempt_d;
  logic        restart_q, restart_d;

  logic [63:0] held_addr_q [llsc_rwl_pkg::MaxHeld];
  logic        held_excl_q [llsc_rwl_pkg::MaxHeld];
  logic        push_en;

  cnt_t        rd_pos;
  cnt_t        rd_pos_m1;
  idx_t        rd_idx;
  logic [63:0] rd_addr;
  logic        rd_excl;

  llsc_rwl_pkg::out_t res;

  assign cfg_ready_o = 1'b1;
  assign s1_go       = s1_valid_q && fifo_room;
  assign in_ready_o  = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  // Stack read position, as the step will see it after any pop.
  always_comb begin
    rd_pos = rel_pos_q;
    if (s1_data_q.func == llsc_rwl_pkg::FuncRelease && phase_q == llsc_rwl_pkg::PhIdle) begin
      rd_pos = held_cnt_q;
    end else if (s1_data_q.func == llsc_rwl_pkg::FuncScResp
                 && phase_q == llsc_rwl_pkg::PhRelSc && !s1_data_q.store_failed
                 && rel_pos_q != '0) begin
      rd_pos = rel_pos_q - cnt_t'(1);
    end
    rd_pos_m1 = rd_pos - cnt_t'(1);
    rd_idx    = (rd_pos == '0) ? '0 : rd_pos_m1[llsc_rwl_pkg::IdxW-1:0];
    rd_addr   = held_addr_q[rd_idx];
    rd_excl   = held_excl_q[rd_idx];
  end

  always_comb begin
    logic [63:0] ours;
    logic [63:0] w;
    logic [31:0] att_inc;
    logic        shared_ok;
    ours      = llsc_rwl_pkg::ExclBit | {32'd0, node_id_q};
    w         = s1_data_q.response_data;
    att_inc   = (attempt_q == 32'hFFFF_FFFF) ? attempt_q : attempt_q + 32'd1;
    shared_ok = !w[63] && !tgt_excl_q && (w != llsc_rwl_pkg::SharedFull);

    phase_d    = phase_q;
    held_cnt_d = held_cnt_q;
    rel_pos_d  = rel_pos_q;
    tgt_addr_d = tgt_addr_q;
    tgt_excl_d = tgt_excl_q;
    attempt_d  = attempt_q;
    restart_d  = restart_q;
    push_en    = 1'b0;

    res.req_kind         = llsc_rwl_pkg::KindNone;
    res.req_address      = '0;
    res.req_bytes        = '0;
    res.req_data         = '0;
    res.status           = llsc_rwl_pkg::StPending;
    res.mismatch_warning = 1'b0;
    res.attempts         = attempt_q;

    unique case (s1_data_q.func)
      llsc_rwl_pkg::FuncAcquire: begin
        if (phase_q != llsc_rwl_pkg::PhIdle) begin
          res.status = llsc_rwl_pkg::StBadPhase;
        end else if (held_cnt_q >= cnt_t'(llsc_rwl_pkg::MaxHeld)) begin
          res.status = llsc_rwl_pkg::StOverflow;
        end else begin
          tgt_addr_d      = s1_data_q.lock_address;
          tgt_excl_d      = s1_data_q.want_exclusive;
          attempt_d       = 32'd1;
          phase_d         = llsc_rwl_pkg::PhAcqLl;
          res.req_kind    = llsc_rwl_pkg::KindLl;
          res.req_address = s1_data_q.lock_address;
          res.req_bytes   = {9'd0, header_bytes_q};
          res.attempts    = 32'd1;
        end
      end
      llsc_rwl_pkg::FuncLlResp: begin
        if (phase_q == llsc_rwl_pkg::PhAcqLl) begin
          if (w == '0 || shared_ok) begin
            phase_d         = llsc_rwl_pkg::PhAcqSc;
            res.req_kind    = llsc_rwl_pkg::KindSc;
            res.req_address = tgt_addr_q;
            res.req_bytes   = llsc_rwl_pkg::WordBytes;
            res.req_data    = tgt_excl_q ? ours : w + 64'd1;
          end else if (tgt_excl_q && w == ours) begin
            attempt_d       = '0;
            phase_d         = llsc_rwl_pkg::PhIdle;
            res.req_kind    = llsc_rwl_pkg::KindRead;
            res.req_address = tgt_addr_q + {57'd0, header_bytes_q};
            res.req_bytes   = node_bytes_q;
            res.status      = llsc_rwl_pkg::StAcquired;
          end else begin
            attempt_d       = att_inc;
            res.req_kind    = llsc_rwl_pkg::KindLl;
            res.req_address = tgt_addr_q;
            res.req_bytes   = {9'd0, header_bytes_q};
            res.attempts    = att_inc;
          end
        end else if (phase_q == llsc_rwl_pkg::PhRelLl) begin
          if (!rd_excl && (w == '0 || w[63])) begin
            res.status = llsc_rwl_pkg::StBadShared;
          end else begin
            phase_d              = llsc_rwl_pkg::PhRelSc;
            res.req_kind         = llsc_rwl_pkg::KindSc;
            res.req_address      = rd_addr;
            res.req_bytes        = llsc_rwl_pkg::WordBytes;
            res.req_data         = rd_excl ? '0 : w - 64'd1;
            res.mismatch_warning = rd_excl && (w != ours);
          end
        end else begin
          res.status = llsc_rwl_pkg::StBadPhase;
        end
      end
      llsc_rwl_pkg::FuncScResp: begin
        if (phase_q == llsc_rwl_pkg::PhAcqSc) begin
          if (s1_data_q.store_failed) begin
            attempt_d       = att_inc;
            phase_d         = llsc_rwl_pkg::PhAcqLl;
            res.req_kind    = llsc_rwl_pkg::KindLl;
            res.req_address = tgt_addr_q;
            res.req_bytes   = {9'd0, header_bytes_q};
            res.attempts    = att_inc;
          end else begin
            if (held_cnt_q < cnt_t'(llsc_rwl_pkg::MaxHeld)) begin
              push_en    = 1'b1;
              held_cnt_d = held_cnt_q + cnt_t'(1);
            end
            attempt_d       = '0;
            phase_d         = llsc_rwl_pkg::PhIdle;
            res.req_kind    = llsc_rwl_pkg::KindRead;
            res.req_address = tgt_addr_q + {57'd0, header_bytes_q};
            res.req_bytes   = node_bytes_q;
            res.status      = llsc_rwl_pkg::StAcquired;
          end
        end else if (phase_q == llsc_rwl_pkg::PhRelSc) begin
          rel_pos_d = rd_pos;
          if (s1_data_q.store_failed || rd_pos != '0) begin
            phase_d         = llsc_rwl_pkg::PhRelLl;
            res.req_kind    = llsc_rwl_pkg::KindLl;
            res.req_address = rd_addr;
            res.req_bytes   = {9'd0, header_bytes_q};
          end else begin
            held_cnt_d = '0;
            phase_d    = llsc_rwl_pkg::PhIdle;
            if (restart_q) begin
              restart_d       = 1'b0;
              res.req_kind    = llsc_rwl_pkg::KindWrite;
              res.req_address = restart_addr_q;
              res.req_bytes   = llsc_rwl_pkg::WordBytes;
              res.status      = llsc_rwl_pkg::StRestart;
            end else begin
              res.status = llsc_rwl_pkg::StReleased;
            end
          end
        end else begin
          res.status = llsc_rwl_pkg::StBadPhase;
        end
      end
      llsc_rwl_pkg::FuncRelease: begin
        if (phase_q != llsc_rwl_pkg::PhIdle) begin
          res.status = llsc_rwl_pkg::StBadPhase;
        end else if (held_cnt_q == '0) begin
          res.status = llsc_rwl_pkg::StReleased;
        end else begin
          restart_d       = s1_data_q.restart_after;
          rel_pos_d       = held_cnt_q;
          phase_d         = llsc_rwl_pkg::PhRelLl;
          res.req_kind    = llsc_rwl_pkg::KindLl;
          res.req_address = rd_addr;
          res.req_bytes   = {9'd0, header_bytes_q};
        end
      end
      default: begin
        res.status = llsc_rwl_pkg::StBadPhase;
      end
    endcase

    // A bad phase or an invalid shared release ends the whole operation.
    if (res.status == llsc_rwl_pkg::StBadPhase || res.status == llsc_rwl_pkg::StBadShared) begin
      phase_d      = llsc_rwl_pkg::PhIdle;
      held_cnt_d   = '0;
      rel_pos_d    = '0;
      restart_d    = 1'b0;
      attempt_d    = '0;
      res.attempts = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= '0;
      header_bytes_q <= 7'd8;
      node_bytes_q   <= 16'd256;
      restart_addr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        llsc_rwl_pkg::CfgNodeId:      node_id_q      <= cfg_data_i[31:0];
        llsc_rwl_pkg::CfgHeaderBytes: header_bytes_q <= cfg_data_i[6:0];
        llsc_rwl_pkg::CfgNodeBytes:   node_bytes_q   <= cfg_data_i[15:0];
        llsc_rwl_pkg::CfgRestartAddr: restart_addr_q <= cfg_data_i;
        default:                      node_id_q      <= node_id_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= llsc_rwl_pkg::PhIdle;
      held_cnt_q <= '0;
      rel_pos_q  <= '0;
      tgt_addr_q <= '0;
      tgt_excl_q <= 1'b0;
      attempt_q  <= '0;
      restart_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_go) begin
        phase_q    <= phase_d;
        held_cnt_q <= held_cnt_d;
        rel_pos_q  <= rel_pos_d;
        tgt_addr_q <= tgt_addr_d;
        tgt_excl_q <= tgt_excl_d;
        attempt_q  <= attempt_d;
        restart_q  <= restart_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_go && push_en) begin
      held_addr_q[held_cnt_q[llsc_rwl_pkg::IdxW-1:0]] <= tgt_addr_q;
      held_excl_q[held_cnt_q[llsc_rwl_pkg::IdxW-1:0]] <= tgt_excl_q;
    end
  end

  llsc_rwl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_go),
    .push_data_i (res),
    .room_o      (fifo_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= cnt_t'(llsc_rwl_pkg::MaxHeld))
    else $error("lock stack count exceeds its depth");

  a_rel_below_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_pos_q <= held_cnt_q)
    else $error("release position beyond the lock stack");

  a_release_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == llsc_rwl_pkg::PhRelLl || phase_q == llsc_rwl_pkg::PhRelSc)
    |-> rel_pos_q != '0)
    else $error("release in progress with nothing left to release");

  a_acquired_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && res.status == llsc_rwl_pkg::StAcquired)
    |=> phase_q == llsc_rwl_pkg::PhIdle && attempt_q == '0)
    else $error("acquire completed without returning to idle");

endmodule

>>> design/llsc_rwl_fifo.sv
// Two-entry result buffer between the lock engine and its output channel.
// Uses llsc_rwl_pkg::out_t as the entry type.
module llsc_rwl_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  llsc_rwl_pkg::out_t push_data_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output llsc_rwl_pkg::out_t out_data_o
);

  llsc_rwl_pkg::out_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q != 2'd2);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> test/ll_sc_lock_checker.sv
// Scoreboard for the LL/SC reader/writer lock engine: predicts the result of every input
// transfer from its own copy of the lock stack and registers, and checks results in order.
// Depends on llsc_rwl_pkg; the testbench top instantiates it beside the engine.
module ll_sc_lock_checker
  import llsc_rwl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output int                 mismatch_count_o,
  output int                 awaited_count_o,
  output int                 checked_count_o
);

  logic [31:0] node_id_q;
  logic [6:0]  header_q;
  logic [15:0] node_bytes_q;
  logic [63:0] restart_addr_q;

  logic [63:0] stack_addr [MaxHeld];
  logic        stack_excl [MaxHeld];
  int unsigned depth;
  int unsigned unwind;
  phase_e      phase_q;
  logic [63:0] target_q;
  logic        target_excl_q;
  logic [31:0] tries_q;
  logic        restart_q;

  out_t awaited [$];
  out_t oldest;

  function automatic out_t pack_result(kind_e kind, logic [63:0] addr, logic [15:0] bytes,
                                       logic [63:0] data, status_e st, logic warn,
                                       logic [31:0] att);
    out_t r;
    r.req_kind         = kind;
    r.req_address      = addr;
    r.req_bytes        = bytes;
    r.req_data         = data;
    r.status           = st;
    r.mismatch_warning = warn;
    r.attempts         = att;
    return r;
  endfunction

  function automatic void drop_operation();
    phase_q   = PhIdle;
    depth     = 0;
    unwind    = 0;
    restart_q = 1'b0;
    tries_q   = '0;
  endfunction

  function automatic out_t phase_error();
    drop_operation();
    return pack_result(KindNone, '0, '0, '0, StBadPhase, 1'b0, '0);
  endfunction

  function automatic out_t ll_request();
    if (tries_q != '1) begin
      tries_q = tries_q + 32'd1;
    end
    phase_q = PhAcqLl;
    return pack_result(KindLl, target_q, {9'd0, header_q}, '0, StPending, 1'b0, tries_q);
  endfunction

  function automatic out_t node_read();
    logic [31:0] att;
    att     = tries_q;
    tries_q = '0;
    phase_q = PhIdle;
    return pack_result(KindRead, target_q + {57'd0, header_q}, node_bytes_q, '0,
                       StAcquired, 1'b0, att);
  endfunction

  function automatic int unsigned top_slot();
    return (unwind >= 1 && unwind <= MaxHeld) ? unwind - 1 : 0;
  endfunction

  function automatic out_t release_ll();
    phase_q = PhRelLl;
    return pack_result(KindLl, stack_addr[top_slot()], {9'd0, header_q}, '0, StPending,
                       1'b0, tries_q);
  endfunction

  function automatic out_t lock_step(in_t item);
    func_e       f;
    logic [63:0] ours;
    logic [63:0] w;
    logic [63:0] nw;
    logic        warn;
    int unsigned slot;
    f    = func_e'(item.func);
    ours = ExclBit | {32'd0, node_id_q};
    w    = item.response_data;
    if (f == FuncAcquire) begin
      if (phase_q != PhIdle) return phase_error();
      if (depth >= MaxHeld) begin
        return pack_result(KindNone, '0, '0, '0, StOverflow, 1'b0, tries_q);
      end
      target_q      = item.lock_address;
      target_excl_q = item.want_exclusive;
      tries_q       = '0;
      return ll_request();
    end else if (f == FuncLlResp) begin
      if (phase_q == PhAcqLl) begin
        if (w == '0 || (!w[63] && !target_excl_q && w != SharedFull)) begin
          phase_q = PhAcqSc;
          return pack_result(KindSc, target_q, WordBytes, target_excl_q ? ours : w + 64'd1,
                             StPending, 1'b0, tries_q);
        end
        if (target_excl_q && w == ours) return node_read();
        return ll_request();
      end
      if (phase_q == PhRelLl) begin
        slot = top_slot();
        if (stack_excl[slot]) begin
          warn = (w != ours);
          nw   = '0;
        end else begin
          if (w == '0 || w[63]) begin
            drop_operation();
            return pack_result(KindNone, '0, '0, '0, StBadShared, 1'b0, '0);
          end
          warn = 1'b0;
          nw   = w - 64'd1;
        end
        phase_q = PhRelSc;
        return pack_result(KindSc, stack_addr[slot], WordBytes, nw, StPending, warn, tries_q);
      end
      return phase_error();
    end else if (f == FuncScResp) begin
      if (phase_q == PhAcqSc) begin
        if (item.store_failed) return ll_request();
        if (depth < MaxHeld) begin
          stack_addr[depth] = target_q;
          stack_excl[depth] = target_excl_q;
          depth++;
        end
        return node_read();
      end
      if (phase_q == PhRelSc) begin
        if (item.store_failed) return release_ll();
        if (unwind > 0) unwind--;
        if (unwind > 0) return release_ll();
        depth   = 0;
        phase_q = PhIdle;
        if (restart_q) begin
          restart_q = 1'b0;
          return pack_result(KindWrite, restart_addr_q, WordBytes, '0, StRestart, 1'b0,
                             tries_q);
        end
        return pack_result(KindNone, '0, '0, '0, StReleased, 1'b0, tries_q);
      end
      return phase_error();
    end
    if (phase_q != PhIdle) return phase_error();
    if (depth == 0) begin
      return pack_result(KindNone, '0, '0, '0, StReleased, 1'b0, tries_q);
    end
    restart_q = item.restart_after;
    unwind    = depth;
    return release_ll();
  endfunction

  function automatic string show(out_t r);
    return $sformatf("kind=%0d addr=%h bytes=%0d data=%h status=%0d warn=%0b att=%0d",
                     r.req_kind, r.req_address, r.req_bytes, r.req_data, r.status,
                     r.mismatch_warning, r.attempts);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q        = '0;
      header_q         = 7'd8;
      node_bytes_q     = 16'd256;
      restart_addr_q   = '0;
      depth            = 0;
      unwind           = 0;
      phase_q          = PhIdle;
      target_q         = '0;
      target_excl_q    = 1'b0;
      tries_q          = '0;
      restart_q        = 1'b0;
      awaited.delete();
      mismatch_count_o = 0;
      awaited_count_o  = 0;
      checked_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgNodeId:      node_id_q      = cfg_data_i[31:0];
          CfgHeaderBytes: header_q       = cfg_data_i[6:0];
          CfgNodeBytes:   node_bytes_q   = cfg_data_i[15:0];
          CfgRestartAddr: restart_addr_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        checked_count_o++;
        if (awaited.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("[%0t] result with nothing awaited: %s", $realtime, show(out_data_i));
          end
          mismatch_count_o++;
        end else begin
          oldest = awaited.pop_front();
          if (oldest.req_kind !== out_data_i.req_kind ||
              oldest.req_address !== out_data_i.req_address ||
              oldest.req_bytes !== out_data_i.req_bytes ||
              oldest.req_data !== out_data_i.req_data ||
              oldest.status !== out_data_i.status ||
              oldest.mismatch_warning !== out_data_i.mismatch_warning ||
              oldest.attempts !== out_data_i.attempts) begin
            if (mismatch_count_o < 10) begin
              $display("[%0t] result %0d differs\n  expected %s\n  actual   %s", $realtime,
                       checked_count_o, show(oldest), show(out_data_i));
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited.insert(awaited.size(), lock_step(in_data_i));
      end
      awaited_count_o = awaited.size();
    end
  end

endmodule

>>> test/tb_ll_sc_reader_writer_lock_engine.sv
// Testbench top for the LL/SC reader/writer lock engine: drives acquire and release
// sequences with random lock words, stalls and register settings, and gives the verdict.
// Depends on llsc_rwl_pkg, the engine and ll_sc_lock_checker, which checks every result.
module tb_ll_sc_reader_writer_lock_engine;
  import llsc_rwl_pkg::*;

  localparam int QuietLimit   = 5000;
  localparam int ConfigSteps  = 6;
  localparam int ItemsPerStep = 285;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  int mismatches;
  int awaited;
  int checked;
  int quiet = 0;
  int sent_n = 0;
  int settings_n = 1;
  int full_n = 0;
  int cut_n = 0;
  bit calm = 1'b0;
  logic [31:0] cur_node_id = '0;
  logic granted_excl [$];

  always #2 clk = ~clk;

  ll_sc_reader_writer_lock_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ll_sc_lock_checker u_lock_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited),
    .checked_count_o  (checked)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("No transfer for %0d cycles.", QuietLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] own_word();
    return ExclBit | {32'd0, cur_node_id};
  endfunction

  function automatic logic [63:0] shared_word();
    logic [63:0] w;
    w = rand_word();
    w[63] = 1'b0;
    case ($urandom_range(0, 9))
      0: w = 64'd1;
      1: w = SharedFull;
      2: w = SharedFull - 64'd1;
      3, 4: w = 64'($urandom_range(2, 20));
      default: if (w == '0) w = 64'd1;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] busy_word(logic excl);
    logic [63:0] w;
    if (excl && $urandom_range(0, 1) == 0) return shared_word();
    if (!excl && $urandom_range(0, 3) == 0) return SharedFull;
    w = rand_word() | ExclBit;
    if (excl && w == own_word()) w[0] = ~w[0];
    return w;
  endfunction

  function automatic logic [63:0] free_word(logic excl);
    logic [63:0] w;
    if (excl || $urandom_range(0, 3) == 0) return '0;
    w = shared_word();
    if (w == SharedFull) w = SharedFull - 64'd1;
    return w;
  endfunction

  // Each call starts and ends at a falling edge; valid stays high into the next transfer
  // when no gap follows.
  task automatic send_op(func_e f, logic [63:0] value, logic flag);
    in_t item;
    int  gap;
    item.func           = f;
    item.lock_address   = rand_word();
    item.want_exclusive = 1'($urandom_range(0, 1));
    item.response_data  = rand_word();
    item.store_failed   = 1'($urandom_range(0, 1));
    item.restart_after  = 1'($urandom_range(0, 1));
    case (f)
      FuncAcquire: begin
        item.lock_address   = value;
        item.want_exclusive = flag;
      end
      FuncLlResp:  item.response_data = value;
      FuncScResp:  item.store_failed = flag;
      FuncRelease: item.restart_after = flag;
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_n++;
  endtask

  task automatic maybe_cut(input func_e want, output bit hit);
    logic [1:0] code;
    hit = ($urandom_range(0, 99) < 3);
    if (hit) begin
      code = want + 2'($urandom_range(1, 3));
      send_op(func_e'(code), rand_word(), 1'($urandom_range(0, 1)));
      granted_excl.delete();
      cut_n++;
    end
  endtask

  task automatic acquire_seq();
    logic excl;
    bit   done;
    bit   hit;
    int   r;
    excl = 1'($urandom_range(0, 1));
    send_op(FuncAcquire, rand_word(), excl);
    if (granted_excl.size() >= MaxHeld) begin
      full_n++;
      return;
    end
    done = 1'b0;
    while (!done) begin
      maybe_cut(FuncLlResp, hit);
      if (hit) return;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_op(FuncLlResp, busy_word(excl), 1'b0);
      end else if (excl && r < 37) begin
        send_op(FuncLlResp, own_word(), 1'b0);
        done = 1'b1;
      end else begin
        send_op(FuncLlResp, free_word(excl), 1'b0);
        maybe_cut(FuncScResp, hit);
        if (hit) return;
        if ($urandom_range(0, 99) < 20) begin
          send_op(FuncScResp, rand_word(), 1'b1);
        end else begin
          send_op(FuncScResp, rand_word(), 1'b0);
          granted_excl.insert(granted_excl.size(), excl);
          done = 1'b1;
        end
      end
    end
  endtask

  task automatic release_seq();
    logic [63:0] w;
    bit          hit;
    send_op(FuncRelease, rand_word(), 1'($urandom_range(0, 1)));
    while (granted_excl.size() > 0) begin
      maybe_cut(FuncLlResp, hit);
      if (hit) return;
      if (granted_excl[$]) begin
        w = ($urandom_range(0, 99) < 80) ? own_word() : rand_word();
      end else if ($urandom_range(0, 99) < 4) begin
        send_op(FuncLlResp, $urandom_range(0, 1) ? 64'd0 : rand_word() | ExclBit, 1'b0);
        granted_excl.delete();
        return;
      end else begin
        w = shared_word();
      end
      send_op(FuncLlResp, w, 1'b0);
      maybe_cut(FuncScResp, hit);
      if (hit) return;
      if ($urandom_range(0, 99) < 15) begin
        send_op(FuncScResp, rand_word(), 1'b1);
      end else begin
        send_op(FuncScResp, rand_word(), 1'b0);
        void'(granted_excl.pop_back());
      end
    end
  endtask

  task automatic run_sequence();
    int r;
    if ($urandom_range(0, 11) == 0) calm = !calm;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_op($urandom_range(0, 1) ? FuncLlResp : FuncScResp, rand_word(),
              1'($urandom_range(0, 1)));
      granted_excl.delete();
      cut_n++;
    end else if (r < 14) begin
      release_seq();
    end else begin
      acquire_seq();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(int step);
    logic [31:0] id;
    logic [6:0]  hdr;
    logic [15:0] nbytes;
    logic [63:0] raddr;
    case (step)
      1: begin
        id     = '1;
        hdr    = 7'd64;
        nbytes = 16'hFFFF;
        raddr  = '1;
      end
      2: begin
        id     = '0;
        hdr    = 7'd1;
        nbytes = 16'd1;
        raddr  = '0;
      end
      default: begin
        id     = $urandom;
        hdr    = 7'($urandom_range(1, 64));
        nbytes = 16'($urandom_range(1, 65535));
        raddr  = rand_word();
      end
    endcase
    write_reg(CfgNodeId, {$urandom, id});
    write_reg(CfgHeaderBytes, {57'(rand_word() >> 7), hdr});
    write_reg(CfgNodeBytes, {48'(rand_word() >> 16), nbytes});
    write_reg(CfgRestartAddr, raddr);
    cfg_valid   <= 1'b0;
    cur_node_id = id;
    settings_n++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default registers, so our exclusive word is bit 63 alone.
    send_op(FuncRelease, rand_word(), 1'b1);
    send_op(FuncAcquire, '1, 1'b1);
    send_op(FuncLlResp, '0, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b1);
    send_op(FuncLlResp, '0, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b0);
    send_op(FuncAcquire, '0, 1'b0);
    send_op(FuncLlResp, SharedFull, 1'b0);
    send_op(FuncLlResp, ExclBit, 1'b0);
    send_op(FuncLlResp, SharedFull - 64'd1, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b0);
    send_op(FuncAcquire, rand_word(), 1'b1);
    send_op(FuncLlResp, ExclBit, 1'b0);
    send_op(FuncRelease, rand_word(), 1'b1);
    send_op(FuncLlResp, SharedFull, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b0);
    send_op(FuncLlResp, ExclBit | 64'd1, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b0);
    send_op(FuncLlResp, rand_word(), 1'b0);
    send_op(FuncAcquire, rand_word(), 1'b0);
    send_op(FuncLlResp, 64'd5, 1'b0);
    send_op(FuncScResp, rand_word(), 1'b0);
    send_op(FuncRelease, rand_word(), 1'b0);
    send_op(FuncLlResp, '0, 1'b0);

    for (int step = 1; step <= ConfigSteps; step++) begin
      drain();
      load_settings(step);
      while (sent_n < 25 + step * ItemsPerStep) run_sequence();
    end
    drain();

    $display("Sent %0d input items under %0d register settings; %0d results checked.",
             sent_n, settings_n, checked);
    $display("Acquires on a full lock stack: %0d; operations ended by stray items: %0d.",
             full_n, cut_n);
    if (mismatches == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
